>>> rtl/axis_angle_vector_rotation_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the axis-angle vector rotation unit
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_VECTOR_ROTATION_UNIT_MACROS_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AAVR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("aavr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define AAVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("aavr: next-cycle check failed");

`endif

>>> rtl/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared types and constants of the axis-angle vector rotation unit.
// ----------------------------------------------------------------------------
package aavr_pkg;

	localparam int TABLE_LEN = 24;
	localparam int ZW        = 34;

	localparam logic signed [ZW-1:0] K_Q30       = 34'sd652032874;
	localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef struct packed {
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} side_t;

	// Arctangent of 2^-i in Q.30, truncated
	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd843314856;
			1: r = 34'sd497837829;
			2: r = 34'sd263043836;
			3: r = 34'sd133525158;
			4: r = 34'sd67021686;
			5: r = 34'sd33543515;
			6: r = 34'sd16775850;
			7: r = 34'sd8388437;
			8: r = 34'sd4194282;
			9: r = 34'sd2097149;
			10: r = 34'sd1048575;
			11: r = 34'sd524287;
			12: r = 34'sd262143;
			13: r = 34'sd131071;
			14: r = 34'sd65535;
			15: r = 34'sd32767;
			16: r = 34'sd16383;
			17: r = 34'sd8191;
			18: r = 34'sd4095;
			19: r = 34'sd2047;
			20: r = 34'sd1023;
			21: r = 34'sd511;
			22: r = 34'sd255;
			23: r = 34'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/aavr_item_if.sv
// ----------------------------------------------------------------------------
// aavr_item_if
// Input channel: vector, axis and angle with valid/ready.
// ----------------------------------------------------------------------------
interface aavr_item_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	logic signed [18:0] angle;

	modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
		input ready);
	modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
		output ready);
endinterface

>>> rtl/aavr_result_if.sv
// ----------------------------------------------------------------------------
// aavr_result_if
// Output channel: rotated vector with valid/ready.
// ----------------------------------------------------------------------------
interface aavr_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;

	modport source (output valid, out_x, out_y, out_z, input ready);
	modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

>>> rtl/aavr_cordic.sv
// ----------------------------------------------------------------------------
// aavr_cordic
// Pipelined rotation-mode CORDIC: quadrant fold, then one stage per step.
// ----------------------------------------------------------------------------
module aavr_cordic #(
	parameter int STEPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [18:0]    angle,
	input  aavr_pkg::side_t       in_side,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [33:0]    sin_q30,
	output logic signed [33:0]    cos_q30,
	output aavr_pkg::side_t       out_side
);
	localparam int N = (STEPS < aavr_pkg::TABLE_LEN) ? STEPS : aavr_pkg::TABLE_LEN;

	logic                  vld_s  [0:N];
	logic                  en     [0:N];
	logic                  neg_s  [0:N];
	logic signed [33:0]    x_s    [0:N];
	logic signed [33:0]    y_s    [0:N];
	logic signed [33:0]    z_s    [0:N];
	aavr_pkg::side_t       side_s [0:N];

	logic signed [33:0] z_in;
	logic signed [33:0] z_fold;
	logic               neg_in;

	// Scale to Q.30 and fold into a half turn
	always_comb begin
		z_in = {angle[18], angle, 14'd0};
		if (z_in > aavr_pkg::HALF_PI_Q30) begin
			z_fold = z_in - aavr_pkg::PI_Q30;
			neg_in = 1'b1;
		end else if (z_in < -aavr_pkg::HALF_PI_Q30) begin
			z_fold = z_in + aavr_pkg::PI_Q30;
			neg_in = 1'b1;
		end else begin
			z_fold = z_in;
			neg_in = 1'b0;
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0] && in_valid) begin
			x_s[0]    <= aavr_pkg::K_Q30;
			y_s[0]    <= '0;
			z_s[0]    <= z_fold;
			neg_s[0]  <= neg_in;
			side_s[0] <= in_side;
		end
	end

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_en
			assign en[k] = !vld_s[k] || en[k+1];
		end
		assign en[N] = !vld_s[N] || out_ready;

		for (k = 1; k <= N; k++) begin : g_step
			logic signed [33:0] xs;
			logic signed [33:0] ys;
			assign xs = x_s[k-1] >>> (k - 1);
			assign ys = y_s[k-1] >>> (k - 1);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en[k] && vld_s[k-1]) begin
					if (!z_s[k-1][33]) begin
						x_s[k] <= x_s[k-1] - ys;
						y_s[k] <= y_s[k-1] + xs;
						z_s[k] <= z_s[k-1] - aavr_pkg::atan_q30(k - 1);
					end else begin
						x_s[k] <= x_s[k-1] + ys;
						y_s[k] <= y_s[k-1] - xs;
						z_s[k] <= z_s[k-1] + aavr_pkg::atan_q30(k - 1);
					end
					neg_s[k]  <= neg_s[k-1];
					side_s[k] <= side_s[k-1];
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[N];
	assign cos_q30   = neg_s[N] ? -x_s[N] : x_s[N];
	assign sin_q30   = neg_s[N] ? -y_s[N] : y_s[N];
	assign out_side  = side_s[N];

endmodule

>>> rtl/axis_angle_vector_rotation_unit.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_unit
// Rotates a Q16.16 vector about a Q2.14 unit axis by a Q3.16 angle.
// ----------------------------------------------------------------------------
// Usage:
//   item   (sink)  : vec_x/y/z, axis_x/y/z, angle; one transfer per rotation.
//   result (source): out_x/y/z, one transfer per accepted item, in order.
//   The axis is used as given and is not normalised. Outputs saturate.
// Pipeline: CORDIC_STEPS + 6 register stages, CORDIC_STEPS <= TABLE_LEN (one
//   fold stage, one stage per CORDIC step, four matrix and product stages,
//   one output register). Throughput: one item per cycle while result.ready
//   is high; the unrolled CORDIC and the dedicated multipliers of each stage
//   let every stage take a new item each cycle.
// Reset: arst_n clears every stage valid bit; the pipeline comes up empty
//   and item.ready is high from the first cycle.
// Stall: each stage holds while it is full and the one after it holds, so
//   bubbles close up and item.ready falls only once every stage is full
//   and result.ready is low. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	aavr_item_if.sink           item,
	aavr_result_if.source       result
);
	aavr_pkg::side_t    side_in;
	aavr_pkg::side_t    cd_side;
	logic               cd_valid;
	logic signed [33:0] cd_sin;
	logic signed [33:0] cd_cos;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	// Hold the side payload (vector and axis) alongside the angle
	always_comb begin
		side_in.vec_x  = item.vec_x;
		side_in.vec_y  = item.vec_y;
		side_in.vec_z  = item.vec_z;
		side_in.axis_x = item.axis_x;
		side_in.axis_y = item.axis_y;
		side_in.axis_z = item.axis_z;
	end

	aavr_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.angle    (item.angle),
		.in_side  (side_in),
		.out_valid(cd_valid),
		.out_ready(en1),
		.sin_q30  (cd_sin),
		.cos_q30  (cd_cos),
		.out_side (cd_side)
	);

	// Advance a stage when it is empty or the stage after it advances
	assign en5 = !v_s5 || result.ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= cd_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// Stage 1: coefficient 1-cos and the axis outer product
	logic signed [15:0] ax [3];
	logic signed [34:0] cf_w;
	logic signed [33:0] sn_s1, cs_s1;
	logic signed [32:0] cf_s1;
	logic signed [31:0] aa_s1 [3][3];
	logic signed [15:0] ax_s1 [3];
	logic signed [31:0] vec_s1 [3];

	always_comb begin
		ax[0] = cd_side.axis_x;
		ax[1] = cd_side.axis_y;
		ax[2] = cd_side.axis_z;
		cf_w  = 35'sd1073741824 - 35'(cd_cos);
	end

	always_ff @(posedge clk) begin
		if (en1 && cd_valid) begin
			sn_s1     <= cd_sin;
			cs_s1     <= cd_cos;
			cf_s1     <= cf_w[32:0];
			vec_s1[0] <= cd_side.vec_x;
			vec_s1[1] <= cd_side.vec_y;
			vec_s1[2] <= cd_side.vec_z;
			for (int i = 0; i < 3; i++) begin
				ax_s1[i] <= ax[i];
				for (int j = 0; j < 3; j++) begin
					aa_s1[i][j] <= ax[i] * ax[j];
				end
			end
		end
	end

	// Stage 2: scaled outer product, axis times sin, rounded cos
	logic signed [33:0] cr_w;
	logic signed [63:0] pcf_s2 [3][3];
	logic signed [49:0] psn_s2 [3];
	logic signed [29:0] cr_s2;
	logic signed [31:0] vec_s2 [3];

	assign cr_w = (cs_s1 + 34'sd8) >>> 4;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			cr_s2 <= cr_w[29:0];
			for (int i = 0; i < 3; i++) begin
				vec_s2[i] <= vec_s1[i];
				psn_s2[i] <= ax_s1[i] * sn_s1;
				for (int j = 0; j < 3; j++) begin
					pcf_s2[i][j] <= cf_s1 * aa_s1[i][j];
				end
			end
		end
	end

	// Stage 3: round the terms and assemble the rotation matrix
	logic signed [63:0] tr_w  [3][3];
	logic signed [49:0] sr_w  [3];
	logic signed [31:0] t_w   [3][3];
	logic signed [31:0] sa_w  [3];
	logic signed [31:0] r_w   [3][3];
	logic signed [31:0] r_s3  [3][3];
	logic signed [31:0] vec_s3 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sr_w[i] = (psn_s2[i] + 50'sd131072) >>> 18;
			sa_w[i] = sr_w[i][31:0];
			for (int j = 0; j < 3; j++) begin
				tr_w[i][j] = (pcf_s2[i][j] + 64'sd2147483648) >>> 32;
				t_w[i][j]  = tr_w[i][j][31:0];
			end
		end
		r_w[0][0] = t_w[0][0] + 32'(cr_s2);
		r_w[1][1] = t_w[1][1] + 32'(cr_s2);
		r_w[2][2] = t_w[2][2] + 32'(cr_s2);
		r_w[0][1] = t_w[0][1] - sa_w[2];
		r_w[0][2] = t_w[0][2] + sa_w[1];
		r_w[1][0] = t_w[1][0] + sa_w[2];
		r_w[1][2] = t_w[1][2] - sa_w[0];
		r_w[2][0] = t_w[2][0] - sa_w[1];
		r_w[2][1] = t_w[2][1] + sa_w[0];
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			r_s3   <= r_w;
			vec_s3 <= vec_s2;
		end
	end

	// Stage 4: vector times matrix, one product per entry
	logic signed [63:0] m_s4 [3][3];

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					m_s4[i][j] <= vec_s3[i] * r_s3[i][j];
				end
			end
		end
	end

	// Stage 5: column sums, round to Q16.16, saturate
	logic signed [65:0] sum_w [3];
	logic signed [65:0] sh_w  [3];
	logic signed [31:0] o_w   [3];
	logic signed [31:0] o_s5  [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum_w[j] = 66'(m_s4[0][j]) + 66'(m_s4[1][j]) + 66'(m_s4[2][j])
				+ 66'sd33554432;
			sh_w[j] = sum_w[j] >>> 26;
			if (sh_w[j] > 66'sd2147483647) begin
				o_w[j] = 32'sh7fffffff;
			end else if (sh_w[j] < -66'sd2147483648) begin
				o_w[j] = 32'sh80000000;
			end else begin
				o_w[j] = sh_w[j][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			o_s5 <= o_w;
		end
	end

	assign result.valid = v_s5;
	assign result.out_x = o_s5[0];
	assign result.out_y = o_s5[1];
	assign result.out_z = o_s5[2];

endmodule

>>> rtl/aavr_chk.sv
// ----------------------------------------------------------------------------
// aavr_chk
// Port-level checks of the rotation unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "axis_angle_vector_rotation_unit_macros.svh"

module aavr_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_y,
	input logic signed [31:0] out_z
);
	// A stalled result holds its value
	`AAVR_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))

	// A free receiver never backs up to the input
	`AAVR_ASSERT_NOW(a_flow, clk, arst_n, out_ready, in_ready)

	// Back-pressure at the input only when the output is full and stalled
	`AAVR_ASSERT_NOW(a_full, clk, arst_n, !in_ready, out_valid && !out_ready)

	// Result valid drops only after a transfer
	`AAVR_ASSERT_NOW(a_rst, clk, arst_n, $fell(out_valid), $past(out_ready))

endmodule

bind axis_angle_vector_rotation_unit aavr_chk u_aavr_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (item.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_x    (result.out_x),
	.out_y    (result.out_y),
	.out_z    (result.out_z)
);
